>>> hdl/dolm_pkg.sv
// Package: shared constants, payload types and helpers for the device lock manager.
`timescale 1ns / 1ps
package dolm_pkg;

    localparam int MAX_PER_CLASS = 8;
    localparam int QUEUE_DEPTH   = 16;
    localparam int ID_BITS       = 16;

    localparam int SLOTS      = 2 * MAX_PER_CLASS;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int WAIT_DEPTH = SLOTS * (2 ** QPTR_W);
    localparam int LIM_W      = 5;

    localparam int CNT_W   = 4;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    typedef enum logic [0:0] {
        REG_DISK_COUNT    = 1'b0,
        REG_PRINTER_COUNT = 1'b1
    } t_reg_idx;

    typedef enum logic [0:0] {
        KIND_REQUEST = 1'b0,
        KIND_RELEASE = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_GRANTED    = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_RELEASED   = 3'd2,
        ST_NOT_IN_USE = 3'd3,
        ST_BAD_NUMBER = 3'd4,
        ST_QUEUE_FULL = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEV,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic        kind;
        logic        device_class;
        logic [3:0]  device_number;
        logic [15:0] process_id;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [15:0] released_id;
        logic        new_owner_valid;
        logic [15:0] new_owner_id;
    } t_out;

    typedef struct packed {
        logic [CNT_W-1:0] disk_count;
        logic [CNT_W-1:0] printer_count;
    } t_cfg;

    typedef logic [QPTR_W-1:0] t_qptr;

    // One device entry as kept in the device memory.
    typedef struct packed {
        logic               busy;
        logic [ID_BITS-1:0] owner;
        t_qptr              head;
        t_qptr              tail;
        logic [FILL_W-1:0]  fill;
    } t_dev;

    function automatic t_qptr qptr_next(t_qptr p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

>>> hdl/dolm_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module dolm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/dolm_cfg.sv
// APB register file for the disk and printer counts.
`timescale 1ns / 1ps
module dolm_cfg
    import dolm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [CNT_W-1:0] r_disk_count;
    logic [CNT_W-1:0] r_printer_count;
    logic             wr_en;
    t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_count    <= '0;
            r_printer_count <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DISK_COUNT:    r_disk_count    <= pwdata[CNT_W-1:0];
                REG_PRINTER_COUNT: r_printer_count <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DISK_COUNT:    prdata = APB_DW'(r_disk_count);
            REG_PRINTER_COUNT: prdata = APB_DW'(r_printer_count);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.disk_count    = r_disk_count;
    assign o_cfg.printer_count = r_printer_count;

endmodule

>>> hdl/dolm_ctrl.sv
// Request sequencer: read-modify-write of the device and wait-queue memories.
`timescale 1ns / 1ps
module dolm_ctrl
    import dolm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_state             r_state, n_state;
    t_in                r_req, n_req;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic               r_bad, n_bad;
    logic [SLOTS-1:0]   r_dev_vld, n_dev_vld;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;

    logic               in_acc;
    logic               out_free;
    logic [LIM_W-1:0]   cnt, lim;
    logic [SLOT_W-1:0]  slot_in;
    logic               bad_in;

    logic               dev_re, dev_we;
    t_dev               dev_rd, dev_wd, cur;
    logic               wait_re, wait_we;
    logic [SLOT_W+QPTR_W-1:0] wait_raddr, wait_waddr;
    logic [ID_BITS-1:0] wait_rd, pid;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign pid      = ID_BITS'(r_req.process_id);

    // Decode device number against the configured count of its class.
    always_comb begin
        cnt     = LIM_W'(i_in_data.device_class ? i_cfg.printer_count : i_cfg.disk_count);
        lim     = (cnt > LIM_W'(MAX_PER_CLASS)) ? LIM_W'(MAX_PER_CLASS) : cnt;
        bad_in  = (i_in_data.device_number == 4'd0) ||
                  (LIM_W'(i_in_data.device_number) > lim);
        slot_in = (i_in_data.device_class ? SLOT_W'(MAX_PER_CLASS) : '0) +
                  SLOT_W'(i_in_data.device_number - 4'd1);
    end

    // An entry never written reads as idle with an empty queue.
    always_comb begin
        cur = dev_rd;
        if (!r_dev_vld[r_slot]) begin
            cur.busy = 1'b0;
            cur.head = '0;
            cur.tail = '0;
            cur.fill = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_slot      = r_slot;
        n_bad       = r_bad;
        n_dev_vld   = r_dev_vld;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_in_ready  = (r_state == S_IDLE);
        dev_re      = 1'b0;
        dev_we      = 1'b0;
        dev_wd      = cur;
        wait_re     = 1'b0;
        wait_we     = 1'b0;
        wait_raddr  = {r_slot, cur.head};
        wait_waddr  = {r_slot, cur.tail};

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req   = i_in_data;
                    n_slot  = slot_in;
                    n_bad   = bad_in;
                    dev_re  = 1'b1;
                    n_state = S_DEV;
                end
            end
            S_DEV: begin
                if (!r_bad && r_req.kind == KIND_RELEASE && cur.busy && cur.fill != '0) begin
                    // Hand off to the queue head: fetch its ID first.
                    wait_re = 1'b1;
                    n_state = S_WAIT;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_state     = S_IDLE;
                    if (r_bad) begin
                        n_out.status = ST_BAD_NUMBER;
                    end else if (r_req.kind == KIND_REQUEST) begin
                        if (!cur.busy) begin
                            dev_we       = 1'b1;
                            dev_wd.busy  = 1'b1;
                            dev_wd.owner = pid;
                            n_out.status = ST_GRANTED;
                        end else if (cur.fill == FILL_W'(QUEUE_DEPTH)) begin
                            n_out.status = ST_QUEUE_FULL;
                        end else begin
                            wait_we      = 1'b1;
                            dev_we       = 1'b1;
                            dev_wd.tail  = qptr_next(cur.tail);
                            dev_wd.fill  = cur.fill + 1'b1;
                            n_out.status = ST_QUEUED;
                        end
                    end else if (!cur.busy) begin
                        n_out.status = ST_NOT_IN_USE;
                    end else begin
                        dev_we            = 1'b1;
                        dev_wd.busy       = 1'b0;
                        n_out.status      = ST_RELEASED;
                        n_out.released_id = 16'(cur.owner);
                    end
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    dev_we                = 1'b1;
                    dev_wd.owner          = wait_rd;
                    dev_wd.head           = qptr_next(cur.head);
                    dev_wd.fill           = cur.fill - 1'b1;
                    n_out_valid           = 1'b1;
                    n_out.status          = ST_RELEASED;
                    n_out.released_id     = 16'(cur.owner);
                    n_out.new_owner_valid = 1'b1;
                    n_out.new_owner_id    = 16'(wait_rd);
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (dev_we) begin
            n_dev_vld[r_slot] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dev_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dev_vld   <= n_dev_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_slot <= n_slot;
        r_bad  <= n_bad;
        r_out  <= n_out;
    end

    dolm_ram #(
        .WIDTH ($bits(t_dev)),
        .DEPTH (SLOTS)
    ) u_dev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (dev_we),
        .i_wr_addr (r_slot),
        .i_wr_data (dev_wd),
        .i_rd_en   (dev_re),
        .i_rd_addr (slot_in),
        .o_rd_data (dev_rd)
    );

    dolm_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wait_we),
        .i_wr_addr (wait_waddr),
        .i_wr_data (pid),
        .i_rd_en   (wait_re),
        .i_rd_addr (wait_raddr),
        .o_rd_data (wait_rd)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hdl/device_owner_fifo_lock_manager_core.sv
// Top level of the device owner lock manager with per-device FIFO wait queues.
//
// Request channel (i_in_valid / o_in_ready / i_in_data): one command per
// request, either a request or a release of a disk or printer, numbered from
// one. Result channel (o_out_valid / i_out_ready / o_out_data): exactly one
// result per request, in order.
// Configuration: APB registers disk_count (0x0) and printer_count (0x4); write
// them only while no request is in flight.
// Timing: a request passes through a registered read of the device memory
// and, when a release hands the device to a waiting process, a registered
// read of the wait-queue memory after it. The result becomes valid in the
// same cycle in which o_in_ready returns high.
// Stall: the result register holds while i_out_ready is low; a finished
// request waits in place, and o_in_ready stays low until it is stored.
// Reset: all devices idle with empty queues, both counts zero; no clearing
// pass is needed, the block takes requests right after reset.
`timescale 1ns / 1ps
module device_owner_fifo_lock_manager_core
    import dolm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data
);

    t_cfg cfg;

    dolm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dolm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> hdl/dolm_chk.sv
// Port-level checker for the lock manager, bound to the top level.
`timescale 1ns / 1ps
module dolm_chk
    import dolm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one is in flight");

    a_handoff_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.new_owner_valid |-> o_out_data.status == ST_RELEASED)
        else $error("new owner reported without a release");

    a_ids_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_RELEASED |->
            o_out_data.released_id == '0 && o_out_data.new_owner_id == '0 &&
            !o_out_data.new_owner_valid)
        else $error("process IDs set on a result that is not a release");

endmodule

bind device_owner_fifo_lock_manager_core dolm_chk u_dolm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> test/tb_top.sv
// Self-checking testbench for the device owner lock manager with FIFO wait queues.
`timescale 1ns / 1ps
module tb_top;
    import dolm_pkg::*;

    localparam int IN_W = $bits(t_in);

    // Mirrors device ownership and wait queues, and checks each result in order.
    class lock_scoreboard;
        logic        busy    [SLOTS];
        logic [15:0] owner   [SLOTS];
        logic [15:0] waiters [SLOTS][QUEUE_DEPTH];
        int          head    [SLOTS];
        int          tail    [SLOTS];
        int          fill    [SLOTS];
        logic [3:0]  disk_cnt;
        logic [3:0]  prn_cnt;
        t_out        expected_q [$];
        int          errors;

        function new();
            foreach (busy[i]) begin
                busy[i] = 1'b0;
                head[i] = 0;
                tail[i] = 0;
                fill[i] = 0;
            end
            disk_cnt = '0;
            prn_cnt  = '0;
            errors   = 0;
        endfunction

        function void set_count(t_reg_idx r, logic [3:0] v);
            if (r == REG_DISK_COUNT) begin
                disk_cnt = v;
            end else begin
                prn_cnt = v;
            end
        endfunction

        // Counts above the class size act as the class size.
        function int limit_of(logic cls);
            int lim;
            lim = cls ? int'(prn_cnt) : int'(disk_cnt);
            return (lim > MAX_PER_CLASS) ? MAX_PER_CLASS : lim;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(t_in c);
            t_out r;
            int   s;
            r = '0;
            r.status = ST_BAD_NUMBER;
            if (c.device_number != 0 && int'(c.device_number) <= limit_of(c.device_class)) begin
                s = int'(c.device_class) * MAX_PER_CLASS + int'(c.device_number) - 1;
                if (c.kind == KIND_REQUEST) begin
                    if (!busy[s]) begin
                        busy[s]  = 1'b1;
                        owner[s] = c.process_id;
                        r.status = ST_GRANTED;
                    end else if (fill[s] >= QUEUE_DEPTH) begin
                        r.status = ST_QUEUE_FULL;
                    end else begin
                        waiters[s][tail[s]] = c.process_id;
                        tail[s] = (tail[s] + 1) % QUEUE_DEPTH;
                        fill[s]++;
                        r.status = ST_QUEUED;
                    end
                end else if (!busy[s]) begin
                    r.status = ST_NOT_IN_USE;
                end else begin
                    r.status      = ST_RELEASED;
                    r.released_id = owner[s];
                    if (fill[s] == 0) begin
                        busy[s] = 1'b0;
                    end else begin
                        // hand the device to the head of its queue
                        r.new_owner_valid = 1'b1;
                        r.new_owner_id    = waiters[s][head[s]];
                        owner[s] = r.new_owner_id;
                        head[s]  = (head[s] + 1) % QUEUE_DEPTH;
                        fill[s]--;
                    end
                end
            end
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                errors++;
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.released_id !== want.released_id) begin
                $error("released_id: expected %h, got %h", want.released_id, got.released_id);
                errors++;
            end
            if (got.new_owner_valid !== want.new_owner_valid) begin
                $error("new_owner_valid: expected %b, got %b",
                       want.new_owner_valid, got.new_owner_valid);
                errors++;
            end
            if (got.new_owner_id !== want.new_owner_id) begin
                $error("new_owner_id: expected %h, got %h", want.new_owner_id, got.new_owner_id);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in               i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out              o_out_data;

    lock_scoreboard sb = new();
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int cmds_sent  = 0;

    device_owner_fifo_lock_manager_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            sb.check_result(o_out_data);
        end
    end

    // Result side: random stalls before each result.
    initial begin : result_sink
        int stall;
        forever begin
            stall = rx_idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
        end
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic t_in mk_cmd(t_kind k, logic cls, logic [3:0] num, logic [15:0] pid);
        t_in c;
        c.kind          = k;
        c.device_class  = cls;
        c.device_number = num;
        c.process_id    = pid;
        return c;
    endfunction

    // Mostly a device in range; now and then any number at all.
    function automatic logic [3:0] pick_number(logic cls);
        int lim;
        lim = sb.limit_of(cls);
        if (lim == 0 || $urandom_range(0, 9) == 0) begin
            return 4'($urandom_range(0, 15));
        end
        return 4'($urandom_range(1, lim));
    endfunction

    task automatic send_cmd(input t_in c);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(c);
        cmds_sent++;
    endtask

    // Hold off new requests until every result is back and the block has settled.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_counts(input logic [3:0] disks, input logic [3:0] printers);
        t_reg_idx   r;
        logic [3:0] v;
        for (int i = 0; i < 2; i++) begin
            r = (i == 0) ? REG_DISK_COUNT : REG_PRINTER_COUNT;
            v = (i == 0) ? disks : printers;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= APB_AW'({r, 2'b00});
            pwdata  <= APB_DW'(v);
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            sb.set_count(r, v);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_mixed(input int n);
        t_in c;
        repeat (n) begin
            c.kind          = ($urandom_range(0, 99) < 55) ? KIND_REQUEST : KIND_RELEASE;
            c.device_class  = 1'($urandom_range(0, 1));
            c.device_number = pick_number(c.device_class);
            c.process_id    = 16'($urandom);
            send_cmd(c);
        end
    endtask

    // Pile waiters onto one device, then release past the end of its queue.
    task automatic run_burst();
        t_in c;
        int  n;
        c.device_class  = 1'($urandom_range(0, 1));
        c.device_number = pick_number(c.device_class);
        n = $urandom_range(8, 20);
        c.kind = KIND_REQUEST;
        repeat (n) begin
            c.process_id = 16'($urandom);
            send_cmd(c);
        end
        c.kind = KIND_RELEASE;
        repeat (n + 1) begin
            c.process_id = 16'($urandom);
            send_cmd(c);
        end
    endtask

    task automatic run_noise(input int n);
        repeat (n) send_cmd(t_in'(IN_W'($urandom)));
    endtask

    initial begin
        int unsigned disk_set [6];
        int unsigned prn_set  [6];
        int target;
        int pick;

        disk_set = '{8, 0, 15, 1, 9, 4};
        prn_set  = '{8, 15, 0, 8, 1, 2};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both counts zero after reset: every number is out of range
        send_cmd(mk_cmd(KIND_REQUEST, 1'b0, 4'd1, 16'h1234));
        send_cmd(mk_cmd(KIND_RELEASE, 1'b1, 4'd1, 16'h0000));
        wait_idle();
        set_counts(4'd3, 4'd15);

        send_cmd(mk_cmd(KIND_REQUEST, 1'b0, 4'd1, 16'h0000));
        send_cmd(mk_cmd(KIND_REQUEST, 1'b0, 4'd1, 16'hFFFF));
        send_cmd(mk_cmd(KIND_REQUEST, 1'b0, 4'd1, 16'h0000));   // owner asks again
        repeat (4) send_cmd(mk_cmd(KIND_RELEASE, 1'b0, 4'd1, 16'h5A5A));
        send_cmd(mk_cmd(KIND_REQUEST, 1'b0, 4'd0, 16'h0001));
        send_cmd(mk_cmd(KIND_REQUEST, 1'b0, 4'd15, 16'h8000));
        send_cmd(mk_cmd(KIND_RELEASE, 1'b1, 4'd9, 16'h0000));   // printer count clamps to 8
        // grant, fill the queue, then one more
        for (int i = 0; i < 18; i++) begin
            send_cmd(mk_cmd(KIND_REQUEST, 1'b1, 4'd8, 16'hA500 + 16'(i)));
        end

        for (int ph = 0; ph < 7; ph++) begin
            wait_idle();
            if (ph < 6) begin
                set_counts(4'(disk_set[ph]), 4'(prn_set[ph]));
            end else begin
                set_counts(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            end
            target = cmds_sent + 115;
            while (cmds_sent < target) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    run_mixed(12);
                end else if (pick < 8) begin
                    run_burst();
                end else begin
                    run_noise(8);
                end
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/dolm_pkg.sv
hdl/dolm_ram.sv
hdl/dolm_cfg.sv
hdl/dolm_ctrl.sv
hdl/device_owner_fifo_lock_manager_core.sv
hdl/dolm_chk.sv
test/tb_top.sv
